/* src/csv_field_tokenizer_top_macros.svh */
// Assertion helpers for the CSV field tokenizer.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef CSV_FIELD_TOKENIZER_TOP_MACROS_SVH
`define CSV_FIELD_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csv tokenizer check failed");

// Next-cycle implication, checked outside reset.
`define CFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csv tokenizer check failed");

`endif

/* src/cft_pkg.sv */
package cft_pkg;

  // Character codes recognized by the tokenizer.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Classification of one byte outside a quoted span.
  typedef enum logic [2:0] {
    BYTE_OTHER,
    BYTE_QUOTE,
    BYTE_COMMA,
    BYTE_BREAK,
    BYTE_SPACE
  } byte_class_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    case (b)
      CH_QUOTE: c = BYTE_QUOTE;
      CH_COMMA: c = BYTE_COMMA;
      CH_LF:    c = BYTE_BREAK;
      CH_CR:    c = BYTE_BREAK;
      CH_SPACE: c = BYTE_SPACE;
      default:  c = BYTE_OTHER;
    endcase
    return c;
  endfunction

endpackage

/* src/csv_field_tokenizer_top.sv */
// Channel   Direction  Handshake          Beat payload
// in_       input      in_valid/in_stall  in_data_byte
// out_      output     out_valid/out_stall row, column, start, length, ends_row
//
// Each byte is held in the input register and its field, if it ends one,
// is then registered in the result register.
// A new byte is accepted every cycle while in_stall is low; throughput is one
// byte per cycle, set by the combinational state update between the two registers.
// rst_n is synchronous and active low; it clears all tokenizer state.
// in_stall rises only while the input register holds a byte and the result
// register is full and stalled, so stalls propagate back in the same cycle.
`include "csv_field_tokenizer_top_macros.svh"

module csv_field_tokenizer_top
  import cft_pkg::*;
#(
  parameter int OFFSET_BITS = 24,
  parameter int COLUMN_BITS = 10,
  parameter int ROW_BITS    = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_data_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ROW_BITS-1:0]    out_row_index,
  output logic [COLUMN_BITS-1:0] out_column_index,
  output logic [OFFSET_BITS-1:0] out_field_start,
  output logic [OFFSET_BITS-1:0] out_field_length,
  output logic                   out_ends_row
);

  localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;
  localparam logic [ROW_BITS-1:0]    ROW_MAX = '1;

  // Input register.
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // Tokenizer state.
  logic                   in_quotes_r, in_quotes_nxt;
  logic                   row_has_content_r, row_has_content_nxt;
  logic [OFFSET_BITS-1:0] byte_offset_r, byte_offset_nxt;
  logic [OFFSET_BITS-1:0] cur_start_r, cur_start_nxt;
  logic [OFFSET_BITS-1:0] cur_length_r, cur_length_nxt;
  logic [COLUMN_BITS-1:0] cur_column_r, cur_column_nxt;
  logic [ROW_BITS-1:0]    cur_row_r, cur_row_nxt;

  // Result register.
  logic                   out_valid_r;
  logic [ROW_BITS-1:0]    out_row_r;
  logic [COLUMN_BITS-1:0] out_column_r;
  logic [OFFSET_BITS-1:0] out_start_r;
  logic [OFFSET_BITS-1:0] out_length_r;
  logic                   out_ends_row_r;

  logic                   out_free;
  logic                   advance;
  logic                   emit;
  logic                   emit_ends_row;
  byte_class_t            cls;
  logic [OFFSET_BITS-1:0] start_base;
  logic [OFFSET_BITS-1:0] length_base;

  // The result register can take a new beat when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign cls      = classify(in_byte_r);

  // The first non-space byte of a row starts a fresh field at its own offset.
  // A comma that opens a row therefore reports an empty field at the comma.
  assign start_base  = row_has_content_r ? cur_start_r : byte_offset_r;
  assign length_base = row_has_content_r ? cur_length_r : '0;

  // Per-byte state update. Saturating increments stop at all ones.
  always_comb begin
    in_quotes_nxt       = in_quotes_r;
    row_has_content_nxt = row_has_content_r;
    cur_start_nxt       = cur_start_r;
    cur_length_nxt      = (cur_length_r == OFS_MAX) ? OFS_MAX : cur_length_r + 1'b1;
    cur_column_nxt      = cur_column_r;
    cur_row_nxt         = cur_row_r;
    byte_offset_nxt     = (byte_offset_r == OFS_MAX) ? OFS_MAX : byte_offset_r + 1'b1;
    emit                = 1'b0;
    emit_ends_row       = 1'b0;

    if (in_quotes_r) begin
      // Inside quotes every byte counts except the closing quote.
      if (cls == BYTE_QUOTE) begin
        in_quotes_nxt  = 1'b0;
        cur_length_nxt = cur_length_r;
      end
    end else begin
      case (cls)
        BYTE_BREAK: begin
          // A line break closes the row only if something was seen in it.
          if (row_has_content_r) begin
            emit          = 1'b1;
            emit_ends_row = 1'b1;
            cur_row_nxt   = (cur_row_r == ROW_MAX) ? ROW_MAX : cur_row_r + 1'b1;
            cur_column_nxt = '0;
          end
          row_has_content_nxt = 1'b0;
        end
        BYTE_SPACE: begin
          // Only the length advances; the default already covers it.
        end
        BYTE_QUOTE: begin
          // Opening quote: start moves one byte past its base, length restarts.
          row_has_content_nxt = 1'b1;
          cur_start_nxt  = (start_base == OFS_MAX) ? OFS_MAX : start_base + 1'b1;
          cur_length_nxt = '0;
          in_quotes_nxt  = 1'b1;
        end
        BYTE_COMMA: begin
          row_has_content_nxt = 1'b1;
          emit           = 1'b1;
          cur_column_nxt = (cur_column_r == COL_MAX) ? COL_MAX : cur_column_r + 1'b1;
          cur_start_nxt  = byte_offset_nxt;
          cur_length_nxt = '0;
        end
        default: begin
          // First real byte of a row restarts the field at this byte.
          if (!row_has_content_r) begin
            row_has_content_nxt = 1'b1;
            cur_start_nxt       = byte_offset_r;
            cur_length_nxt      = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      in_quotes_r       <= 1'b0;
      row_has_content_r <= 1'b0;
      byte_offset_r     <= '0;
      cur_start_r       <= '0;
      cur_length_r      <= '0;
      cur_column_r      <= '0;
      cur_row_r         <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        in_quotes_r       <= in_quotes_nxt;
        row_has_content_r <= row_has_content_nxt;
        byte_offset_r     <= byte_offset_nxt;
        cur_start_r       <= cur_start_nxt;
        cur_length_r      <= cur_length_nxt;
        cur_column_r      <= cur_column_nxt;
        cur_row_r         <= cur_row_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_data_byte;
    end
    if (advance && emit) begin
      out_row_r      <= cur_row_r;
      out_column_r   <= cur_column_r;
      out_start_r    <= start_base;
      out_length_r   <= length_base;
      out_ends_row_r <= emit_ends_row;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_index    = out_row_r;
  assign out_column_index = out_column_r;
  assign out_field_start  = out_start_r;
  assign out_field_length = out_length_r;
  assign out_ends_row     = out_ends_row_r;

  // A byte held back by a full result register stays in the input register.
  `CFT_ASSERT_NEXT(a_hold_input, in_stall, in_valid_r && $stable(in_byte_r))
  // A quoted span opens only on a quote byte that was processed.
  `CFT_ASSERT_NEXT(a_quote_open, advance && !in_quotes_r && in_byte_r != CH_QUOTE, !in_quotes_r)
  // The column only moves within a row that has content.
  `CFT_ASSERT_NOW(a_column_reset, !row_has_content_r, cur_column_r == '0)
  // A new result never overwrites one that is still stalled.
  `CFT_ASSERT_NOW(a_no_overwrite, out_valid_r && out_stall, !advance)

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

// Testbench for the byte-serial CSV field tokenizer.
//
// A queue of CSV text is filled by the main initial block, one phase at a
// time. A clocked driver takes bytes from that queue and offers them on the
// in_ channel. Every byte that the block accepts is fed through a local
// tokenizer that keeps its own copy of the quote, row, column and offset
// state. Each field that the local tokenizer finishes is appended to a queue
// of pending fields. A clocked monitor compares every result beat against the
// oldest pending field, one field at a time.
//
// Stimulus starts with a short hand-written text: leading spaces, a comma
// as the first byte of a row, empty and blank lines, quoted commas and line
// breaks, a quote in the middle of a field, and the byte extremes. The rest is
// mostly well-formed rows with random content, mixed with bursts of random
// bytes.
module tb_top
  import cft_pkg::*;
();

  localparam int OFS_W = 24;
  localparam int COL_W = 10;
  localparam int ROW_W = 20;

  // Cycles that the receiver holds off for during the long back-pressure test.
  localparam int HOLD_CYCLES = 120;
  // Random bytes queued in each random phase.
  localparam int PHASE_BYTES = 190;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] len;
    logic             ends_row;
  } field_rec_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_data_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ROW_W-1:0] out_row_index;
  logic [COL_W-1:0] out_column_index;
  logic [OFS_W-1:0] out_field_start;
  logic [OFS_W-1:0] out_field_length;
  logic             out_ends_row;

  csv_field_tokenizer_top #(
    .OFFSET_BITS(OFS_W),
    .COLUMN_BITS(COL_W),
    .ROW_BITS   (ROW_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_index   (out_row_index),
    .out_column_index(out_column_index),
    .out_field_start (out_field_start),
    .out_field_length(out_field_length),
    .out_ends_row    (out_ends_row)
  );

  always #5 clk = ~clk;

  // Bytes still to be offered, and fields finished but not yet seen on out_.
  logic [7:0] csv_text[$];
  field_rec_t pending_fields[$];

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int idle_pct = 0;
  int stall_pct = 0;

  // The main block bumps the request count; the monitor serves each request
  // with one long hold-off that it counts itself.
  int holds_requested = 0;
  int holds_served = 0;
  int hold_left = 0;

  int err_count = 0;

  // Local tokenizer state. Reset is applied once at the start, so the
  // declaration values stand for the post-reset state.
  logic             tk_in_quotes = 1'b0;
  logic             tk_row_open = 1'b0;
  logic [OFS_W-1:0] tk_offset = '0;
  logic [OFS_W-1:0] tk_start = '0;
  logic [OFS_W-1:0] tk_len = '0;
  logic [COL_W-1:0] tk_col = '0;
  logic [ROW_W-1:0] tk_row = '0;

  // Generator bookkeeping. Every quote byte flips the quoted state, so the
  // parity of quotes queued so far tells whether the text is inside quotes.
  logic gen_quote_open = 1'b0;
  int   gen_count = 0;

  // Advances the local tokenizer by one accepted byte. A finished field is
  // queued with the row and column that were current before the byte.
  task automatic tokenize_byte(input logic [7:0] b);
    field_rec_t f;
    f.row      = tk_row;
    f.col      = tk_col;
    f.start    = tk_start;
    f.len      = tk_len;
    f.ends_row = 1'b0;
    if (tk_in_quotes) begin
      // Inside quotes everything but a quote is plain field content.
      if (b == CH_QUOTE) begin
        tk_in_quotes = 1'b0;
      end else if (~&tk_len) begin
        tk_len = tk_len + 1'b1;
      end
    end else if (b == CH_LF || b == CH_CR) begin
      // A line break closes the row only if the row held a non-space byte;
      // otherwise it is a blank line and the row number stays put.
      if (tk_row_open) begin
        f.ends_row = 1'b1;
        pending_fields.push_back(f);
        if (~&tk_row) tk_row = tk_row + 1'b1;
        tk_col = '0;
      end
      tk_row_open = 1'b0;
      if (~&tk_len) tk_len = tk_len + 1'b1;
    end else if (b == CH_SPACE) begin
      if (~&tk_len) tk_len = tk_len + 1'b1;
    end else begin
      // The first non-space byte of a row anchors the field start.
      if (!tk_row_open) begin
        tk_row_open = 1'b1;
        tk_start    = tk_offset;
        tk_len      = '0;
      end
      if (b == CH_QUOTE) begin
        // An opening quote moves the start one byte on and restarts the
        // length, wherever in the field it stands.
        if (~&tk_start) tk_start = tk_start + 1'b1;
        tk_len       = '0;
        tk_in_quotes = 1'b1;
      end else if (b == CH_COMMA) begin
        // A comma that opens a row closes an empty field at its own offset.
        f.start = tk_start;
        f.len   = tk_len;
        pending_fields.push_back(f);
        if (~&tk_col) tk_col = tk_col + 1'b1;
        tk_start = (&tk_offset) ? tk_offset : tk_offset + 1'b1;
        tk_len   = '0;
      end else if (~&tk_len) begin
        tk_len = tk_len + 1'b1;
      end
    end
    if (~&tk_offset) tk_offset = tk_offset + 1'b1;
  endtask

  // Driver: a beat leaves the payload registers only once it is accepted, so
  // a stalled byte stays on the port unchanged.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) tokenize_byte(in_data_byte);
      if (!in_valid || !in_stall) begin
        if (csv_text.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid     <= 1'b1;
          in_data_byte <= csv_text.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    err_count++;
  endtask

  // Compares one result beat against the oldest finished field.
  task automatic check_result();
    field_rec_t want;
    if (pending_fields.size() == 0) begin
      $display("%0t: result with no field pending: expected none, got row %0d col %0d",
               $time, out_row_index, out_column_index);
      err_count++;
      return;
    end
    want = pending_fields.pop_front();
    if (out_row_index !== want.row)
      report_mismatch("row_index", 64'(want.row), 64'(out_row_index));
    if (out_column_index !== want.col)
      report_mismatch("column_index", 64'(want.col), 64'(out_column_index));
    if (out_field_start !== want.start)
      report_mismatch("field_start", 64'(want.start), 64'(out_field_start));
    if (out_field_length !== want.len)
      report_mismatch("field_length", 64'(want.len), 64'(out_field_length));
    if (out_ends_row !== want.ends_row)
      report_mismatch("ends_row", 64'(want.ends_row), 64'(out_ends_row));
  endtask

  // Monitor and receiver. A long hold-off takes priority over random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (holds_served < holds_requested) begin
        out_stall    <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        holds_served <= holds_served + 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    csv_text.push_back(b);
    if (b == CH_QUOTE) gen_quote_open = !gen_quote_open;
    gen_count++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic is_marker(input logic [7:0] b);
    return b == CH_QUOTE || b == CH_COMMA || b == CH_LF || b == CH_CR || b == CH_SPACE;
  endfunction

  function automatic logic [7:0] pick_marker();
    logic [7:0] b;
    case ($urandom_range(4))
      0: b = CH_QUOTE;
      1: b = CH_COMMA;
      2: b = CH_LF;
      3: b = CH_CR;
      default: b = CH_SPACE;
    endcase
    return b;
  endfunction

  // Any byte that has no special meaning to the tokenizer.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (is_marker(b)) b = 8'($urandom_range(255));
    return b;
  endfunction

  // One well-formed row: optional blank line ahead of it, then a mix of
  // empty, plain and quoted fields with random leading spaces.
  task automatic gen_row();
    int ncols;
    int n;
    logic [7:0] b;
    if (gen_quote_open) push_byte(CH_QUOTE);
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(1) != 0) push_text("\n");
      else push_text(" \r");
    end
    ncols = $urandom_range(6, 1);
    for (int c = 0; c < ncols; c++) begin
      if (c != 0) push_byte(CH_COMMA);
      n = $urandom_range(3) == 0 ? $urandom_range(2, 1) : 0;
      repeat (n) push_byte(CH_SPACE);
      case ($urandom_range(3))
        0: ;
        1: begin
          // Quoted span with commas and line breaks buried in it.
          push_byte(CH_QUOTE);
          repeat ($urandom_range(5)) begin
            if ($urandom_range(3) == 0) begin
              b = pick_marker();
              if (b == CH_QUOTE) b = CH_COMMA;
            end else begin
              b = 8'($urandom_range(255));
              if (b == CH_QUOTE) b = CH_LF;
            end
            push_byte(b);
          end
          push_byte(CH_QUOTE);
          if ($urandom_range(4) == 0) push_byte(plain_byte());
        end
        default: begin
          repeat ($urandom_range(6, 1))
            push_byte($urandom_range(7) == 0 ? CH_SPACE : plain_byte());
        end
      endcase
    end
    case ($urandom_range(2))
      0: push_byte(CH_LF);
      1: push_byte(CH_CR);
      default: push_text("\r\n");
    endcase
  endtask

  // Mostly well-formed rows, with bursts of arbitrary bytes that can leave
  // quotes open and rows half finished.
  task automatic gen_random(input int nbytes);
    int stop_at;
    stop_at = gen_count + nbytes;
    while (gen_count < stop_at) begin
      if ($urandom_range(99) < 80) begin
        gen_row();
      end else begin
        repeat ($urandom_range(8, 1))
          push_byte($urandom_range(1) ? pick_marker() : 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic set_phase(input int idle, input int stall);
    @(negedge clk);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  // Lets the sender run dry and waits until every finished field has come out.
  task automatic drain();
    while (csv_text.size() != 0 || in_valid) @(posedge clk);
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Hand-written text. Leading spaces before the first field, a comma that
    // opens a row, an empty line and a blank one, the byte extremes as field
    // content, quoted commas and line breaks, and a quote inside a field.
    set_phase(0, 0);
    push_text("  a,b\n");
    push_text(",\r");
    push_text("\n \r");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text(",\"x,\ny\",a\"b\"c\r");
    drain();

    // Full rate on both sides, plus one long receiver hold-off while the
    // sender keeps offering, so the block backs up and stalls its input.
    set_phase(0, 0);
    gen_random(PHASE_BYTES);
    @(negedge clk);
    holds_requested++;
    drain();

    set_phase(53, 0);
    gen_random(PHASE_BYTES);
    drain();

    set_phase(0, 53);
    gen_random(PHASE_BYTES);
    drain();

    set_phase(19, 19);
    gen_random(PHASE_BYTES);
    while (csv_text.size() != 0 || in_valid) @(posedge clk);

    // Quiet the receiver so the last results are not held back.
    set_phase(0, 0);
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
